@@ hw/rtl/rtt_pkg.sv @@
`timescale 1ns / 1ps
package rtt_pkg;
    localparam int MaxEntries = 16;
    localparam int IdxW = $clog2(MaxEntries);
    localparam int CntW = $clog2(MaxEntries + 1);
    localparam int KeyW = 33;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_REMOVE = 3'd1,
        OP_MARK_SENT = 3'd2,
        OP_TICK = 3'd3,
        OP_CLEAR = 3'd4
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK = 2'd0,
        ST_FULL = 2'd1,
        ST_DUP = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef struct packed {
        logic execute;
        logic report;
    } cmd_t;
endpackage

@@ hw/rtl/rtt_datapath.sv @@
`timescale 1ns / 1ps
module rtt_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rtt_pkg::cmd_t         cmd,
    input  logic [2:0]            opcode,
    input  logic [rtt_pkg::KeyW-1:0] key,
    input  logic [31:0]           message_ref,
    input  logic [15:0]           timeout_ticks,
    input  logic [7:0]            retry_limit,
    output logic                  result_valid,
    output logic [1:0]            status,
    output logic [4:0]            entry_count,
    output logic                  pending_valid,
    output logic [31:0]           pending_ref,
    output logic                  overtime_valid,
    output logic [31:0]           overtime_ref
);
    import rtt_pkg::*;

    logic [KeyW-1:0]  key_reg [MaxEntries];
    logic [31:0]      ref_reg [MaxEntries];
    logic [MaxEntries-1:0] sent_reg, sent_next, ot_reg, ot_next;
    logic [15:0]      tick_reg [MaxEntries];
    logic [15:0]      tick_next [MaxEntries];
    logic [7:0]       retry_reg [MaxEntries];
    logic [7:0]       retry_next [MaxEntries];
    logic [CntW-1:0]  count_reg, count_next;
    logic [1:0]       status_reg, status_next;
    logic             res_valid_reg;

    logic [MaxEntries-1:0] hit_vec, live;
    logic                  hit_any;
    logic [IdxW-1:0]       hit_idx;
    logic                  do_add, do_remove;

    always_comb
    begin
        hit_idx = '0;
        hit_any = 1'b0;
        for (int i = 0; i < MaxEntries; i++)
        begin
            live[i] = (CntW'(i) < count_reg);
            hit_vec[i] = live[i] && (key_reg[i] == key);
        end
        for (int i = MaxEntries - 1; i >= 0; i--)
        begin
            if (hit_vec[i])
            begin
                hit_any = 1'b1;
                hit_idx = IdxW'(i);
            end
        end
    end

    always_comb
    begin
        logic [15:0] t;
        logic [7:0]  r;
        sent_next = sent_reg;
        ot_next = ot_reg;
        tick_next = tick_reg;
        retry_next = retry_reg;
        count_next = count_reg;
        status_next = ST_OK;
        do_add = 1'b0;
        do_remove = 1'b0;
        t = '0;
        r = '0;
        case (opcode)
            OP_ADD:
            begin
                if (count_reg >= CntW'(MaxEntries))
                    status_next = ST_FULL;
                else if (hit_any)
                    status_next = ST_DUP;
                else
                begin
                    do_add = 1'b1;
                    sent_next[count_reg[IdxW-1:0]] = 1'b0;
                    ot_next[count_reg[IdxW-1:0]] = 1'b0;
                    tick_next[count_reg[IdxW-1:0]] = '0;
                    retry_next[count_reg[IdxW-1:0]] = '0;
                    count_next = count_reg + 1'b1;
                end
            end
            OP_REMOVE:
            begin
                if (!hit_any)
                    status_next = ST_NOT_FOUND;
                else
                begin
                    do_remove = 1'b1;
                    for (int i = 0; i < MaxEntries - 1; i++)
                    begin
                        if (IdxW'(i) >= hit_idx)
                        begin
                            sent_next[i] = sent_reg[i + 1];
                            ot_next[i] = ot_reg[i + 1];
                            tick_next[i] = tick_reg[i + 1];
                            retry_next[i] = retry_reg[i + 1];
                        end
                    end
                    sent_next[count_reg[IdxW-1:0] - 1'b1] = 1'b0;
                    ot_next[count_reg[IdxW-1:0] - 1'b1] = 1'b0;
                    tick_next[count_reg[IdxW-1:0] - 1'b1] = '0;
                    retry_next[count_reg[IdxW-1:0] - 1'b1] = '0;
                    count_next = count_reg - 1'b1;
                end
            end
            OP_MARK_SENT:
            begin
                if (!hit_any)
                    status_next = ST_NOT_FOUND;
                else
                    sent_next[hit_idx] = 1'b1;
            end
            OP_TICK:
            begin
                for (int i = 0; i < MaxEntries; i++)
                begin
                    if (live[i])
                    begin
                        t = tick_reg[i];
                        r = retry_reg[i];
                        if (!ot_reg[i] && sent_reg[i])
                            t = t + 16'd1;
                        if (t >= timeout_ticks)
                        begin
                            if (r != 8'hFF)
                                r = r + 8'd1;
                            t = '0;
                            if (r >= retry_limit)
                                ot_next[i] = 1'b1;
                            else
                                sent_next[i] = 1'b0;
                        end
                        tick_next[i] = t;
                        retry_next[i] = r;
                    end
                end
            end
            OP_CLEAR:
            begin
                sent_next = '0;
                ot_next = '0;
                for (int i = 0; i < MaxEntries; i++)
                begin
                    tick_next[i] = '0;
                    retry_next[i] = '0;
                end
                count_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sent_reg <= '0;
            ot_reg <= '0;
            count_reg <= '0;
            status_reg <= ST_OK;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < MaxEntries; i++)
            begin
                tick_reg[i] <= '0;
                retry_reg[i] <= '0;
            end
        end
        else
        begin
            res_valid_reg <= cmd.report;
            if (cmd.execute)
            begin
                sent_reg <= sent_next;
                ot_reg <= ot_next;
                tick_reg <= tick_next;
                retry_reg <= retry_next;
                count_reg <= count_next;
                status_reg <= status_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute && do_add)
        begin
            key_reg[count_reg[IdxW-1:0]] <= key;
            ref_reg[count_reg[IdxW-1:0]] <= message_ref;
        end
        if (cmd.execute && do_remove)
        begin
            for (int i = 0; i < MaxEntries - 1; i++)
            begin
                if (IdxW'(i) >= hit_idx)
                begin
                    key_reg[i] <= key_reg[i + 1];
                    ref_reg[i] <= ref_reg[i + 1];
                end
            end
        end
    end

    always_comb
    begin
        pending_valid = 1'b0;
        pending_ref = '0;
        overtime_valid = 1'b0;
        overtime_ref = '0;
        for (int i = MaxEntries - 1; i >= 0; i--)
        begin
            if ((CntW'(i) < count_reg) && !sent_reg[i])
            begin
                pending_valid = 1'b1;
                pending_ref = ref_reg[i];
            end
            if ((CntW'(i) < count_reg) && ot_reg[i])
            begin
                overtime_valid = 1'b1;
                overtime_ref = ref_reg[i];
            end
        end
    end

    assign result_valid = res_valid_reg;
    assign status = status_reg;
    assign entry_count = 5'(count_reg);
endmodule

@@ hw/rtl/rtt_control.sv @@
`timescale 1ns / 1ps
module rtt_control (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    output rtt_pkg::cmd_t cmd
);
    import rtt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.execute = 1'b1;
                    cmd.report = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end
endmodule

@@ hw/rtl/retransmit_timeout_table.sv @@
`timescale 1ns / 1ps
// Table of pending transmissions, up to 16 entries kept in insertion order.
// An operation is a transfer taken at a clock edge where start is high and
// busy is low; the key fields, opcode and message_ref are sampled then.
// The operation is executed at that edge and its result appears on the next
// cycle, marked by done for exactly one cycle.
// Busy stays high after each transfer, so a new operation cannot be taken
// until busy falls. This is set by the controller, which holds off a new
// operation while the result registers are being presented.
// The receiver cannot stall, so a result not taken while done is high is
// lost.
// Configuration writes use cfg_we, cfg_index and cfg_data; index 0 is the
// timeout in ticks and index 1 the retry limit. Write only while idle.
// Reset empties the table and restores a timeout of 100 and a limit of 3.
module retransmit_timeout_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic [2:0]  opcode,
    input  logic [7:0]  dest_mac_id,
    input  logic [7:0]  source_id,
    input  logic [7:0]  src_mac_id,
    input  logic [7:0]  func_id,
    input  logic        ack_bit,
    input  logic [31:0] message_ref,
    output logic        done,
    output logic [1:0]  status,
    output logic [4:0]  entry_count,
    output logic        pending_valid,
    output logic [31:0] pending_ref,
    output logic        overtime_valid,
    output logic [31:0] overtime_ref
);
    import rtt_pkg::*;

    cmd_t        cmd;
    logic [15:0] timeout_reg;
    logic [7:0]  limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= 16'd100;
            limit_reg <= 8'd3;
        end
        else if (cfg_we)
        begin
            if (cfg_index == 1'b0)
                timeout_reg <= cfg_data;
            else
                limit_reg <= cfg_data[7:0];
        end
    end

    rtt_control u_control (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    rtt_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .opcode         (opcode),
        .key            ({dest_mac_id, source_id, src_mac_id, func_id, ack_bit}),
        .message_ref    (message_ref),
        .timeout_ticks  (timeout_reg),
        .retry_limit    (limit_reg),
        .result_valid   (done),
        .status         (status),
        .entry_count    (entry_count),
        .pending_valid  (pending_valid),
        .pending_ref    (pending_ref),
        .overtime_valid (overtime_valid),
        .overtime_ref   (overtime_ref)
    );
endmodule
